### rtl/mps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the max priority store.
// Used by mps_cell, max_priority_store and the testbench; depends on nothing else.
package mps_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_VALUE_BITS = 16;
	localparam int FIELD_W        = 16;
	localparam int OCC_W          = 5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

### rtl/max_priority_store.sv
`timescale 1ns / 1ps
// The result of a request appears on the result ports in the cycle after acceptance.
// Throughput: one request per cycle; busy stays low, since every cell of the sorted chain
// settles an insert or a remove with one update of its own register.
// Reset clears the entry count and the result strobe; the stored values need no reset.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
// Depends on mps_pkg and mps_cell.
module max_priority_store #(
	parameter int CAPACITY   = mps_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = mps_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [mps_pkg::FIELD_W-1:0] value,
	output logic                        done,
	output logic [mps_pkg::FIELD_W-1:0] removed_value,
	output logic [1:0]                  status,
	output logic [mps_pkg::OCC_W-1:0]   occupancy
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [CNT_W-1:0]      count_q;
	logic [31:0]           value_ext;
	logic [VALUE_BITS-1:0] new_val;
	mps_pkg::cell_ctl_t    ctl;

	logic [CAPACITY-1:0]   occ;
	logic [CAPACITY-1:0]   gt;
	logic [VALUE_BITS-1:0] vals [CAPACITY];

	logic                        done_q;
	logic [mps_pkg::FIELD_W-1:0] removed_q;
	mps_pkg::status_t            status_q;
	logic [31:0]                 head_ext;
	logic [31:0]                 cnt_ext;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign value_ext = 32'(value);
	assign new_val   = value_ext[VALUE_BITS-1:0];

	assign ctl.ins = accept & (command == mps_pkg::CMD_INSERT) & ~full;
	assign ctl.rem = accept & (command == mps_pkg::CMD_REMOVE) & ~empty;

	// The chain is kept sorted in descending order, so cell 0 always holds the largest value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		mps_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.new_val  (new_val),
			.occupied (occ[i]),
			.prev_gt  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
			.prev_val ((i == 0) ? new_val : vals[(i == 0) ? 0 : i-1]),
			.next_val ((i == CAPACITY-1) ? vals[i] : vals[(i == CAPACITY-1) ? i : i+1]),
			.gt       (gt[i]),
			.val      (vals[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head_ext = 32'(vals[0]);

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= '0;
			status_q  <= mps_pkg::ST_OK;
			if (command == mps_pkg::CMD_REMOVE) begin
				if (empty) begin
					status_q <= mps_pkg::ST_EMPTY;
				end else begin
					removed_q <= head_ext[mps_pkg::FIELD_W-1:0];
				end
			end else if (full) begin
				status_q <= mps_pkg::ST_FULL;
			end
		end
	end

	assign cnt_ext       = 32'(count_q);
	assign done          = done_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign occupancy     = cnt_ext[mps_pkg::OCC_W-1:0];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result strobe without an accepted request");

	a_head_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (vals[0] >= vals[1]))
		else $error("chain head is not the largest entry");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rem |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not lower the entry count");
`endif

endmodule

### rtl/mps_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one value and trades it with its neighbors.
// Depends on mps_pkg.
module mps_cell #(
	parameter int VALUE_BITS = mps_pkg::DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  mps_pkg::cell_ctl_t    ctl,
	input  logic [VALUE_BITS-1:0] new_val,
	input  logic                  occupied,
	input  logic                  prev_gt,
	input  logic [VALUE_BITS-1:0] prev_val,
	input  logic [VALUE_BITS-1:0] next_val,
	output logic                  gt,
	output logic [VALUE_BITS-1:0] val
);

	logic [VALUE_BITS-1:0] val_q;

	// The new value belongs at or above this place when the cell is empty or smaller.
	assign gt  = ctl.ins & (~occupied | (new_val > val_q));
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.rem) begin
			val_q <= next_val;
		end else if (ctl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt) begin
				val_q <= new_val;
			end
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_priority_store: directed and random insert/remove requests,
// checked against a shadow store kept inside the bench. Depends on mps_pkg and the RTL.
module tb;

	localparam int CAPACITY   = mps_pkg::DEF_CAPACITY;
	localparam int VALUE_BITS = mps_pkg::DEF_VALUE_BITS;
	localparam logic [mps_pkg::FIELD_W-1:0] VALUE_MASK =
		mps_pkg::FIELD_W'((64'd1 << VALUE_BITS) - 1);
	localparam int NUM_RANDOM = 1150;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		bit                          drain;
		logic                        cmd;
		logic [mps_pkg::FIELD_W-1:0] val;
		int unsigned                 gap;
	} request_t;

	typedef struct {
		logic [mps_pkg::FIELD_W-1:0] removed;
		mps_pkg::status_t            st;
		logic [mps_pkg::OCC_W-1:0]   occ;
	} outcome_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        command = mps_pkg::CMD_INSERT;
	logic [mps_pkg::FIELD_W-1:0] value = '0;
	logic                        busy;
	logic                        done;
	logic [mps_pkg::FIELD_W-1:0] removed_value;
	logic [1:0]                  status;
	logic [mps_pkg::OCC_W-1:0]   occupancy;

	request_t    request_q[$];
	outcome_t    outcome_q[$];
	logic [mps_pkg::FIELD_W-1:0] shadow_vals[CAPACITY];
	int          shadow_count = 0;
	int unsigned gap_left = 0;
	int unsigned mismatches = 0;
	int unsigned n_checked = 0;
	int unsigned n_insert = 0, n_remove = 0, n_full = 0, n_empty = 0;
	int unsigned cycle_count = 0;

	max_priority_store dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.value         (value),
		.done          (done),
		.removed_value (removed_value),
		.status        (status),
		.occupancy     (occupancy)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one accepted request to the shadow store and queues the outcome it must produce.
	function automatic void shadow_apply(input logic cmd,
			input logic [mps_pkg::FIELD_W-1:0] val);
		outcome_t res;
		int best;
		res.removed = '0;
		res.st = mps_pkg::ST_OK;
		if (cmd == mps_pkg::CMD_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				res.st = mps_pkg::ST_FULL;
				n_full++;
			end else begin
				shadow_vals[shadow_count] = val & VALUE_MASK;
				shadow_count++;
				n_insert++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.st = mps_pkg::ST_EMPTY;
				n_empty++;
			end else begin
				best = 0;
				for (int i = 1; i < shadow_count; i++)
					if (shadow_vals[i] > shadow_vals[best])
						best = i;
				res.removed = shadow_vals[best];
				shadow_count--;
				shadow_vals[best] = shadow_vals[shadow_count];
				n_remove++;
			end
		end
		res.occ = mps_pkg::OCC_W'(shadow_count);
		outcome_q.insert(outcome_q.size(), res);
	endfunction

	task automatic push_req(input logic cmd, input logic [mps_pkg::FIELD_W-1:0] val,
			input int unsigned gap);
		request_t r;
		r.drain = 1'b0;
		r.cmd = cmd;
		r.val = val;
		r.gap = gap;
		request_q.insert(request_q.size(), r);
	endtask

	task automatic push_drain();
		request_t r;
		r.drain = 1'b1;
		r.cmd = mps_pkg::CMD_INSERT;
		r.val = '0;
		r.gap = 0;
		request_q.insert(request_q.size(), r);
	endtask

	// Driver: a request is taken when start is high and busy is low at the edge.
	always @(posedge clk or negedge arst_n) begin : driver
		request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			command <= mps_pkg::CMD_INSERT;
			value <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				shadow_apply(command, value);
			if (start && busy) begin
				// Hold the request until the block takes it.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (request_q.size() > 0) begin
				nxt = request_q[0];
				if (nxt.drain) begin
					start <= 1'b0;
					if (outcome_q.size() == 0)
						void'(request_q.pop_front());
				end else begin
					void'(request_q.pop_front());
					start <= 1'b1;
					command <= nxt.cmd;
					value <= nxt.val;
					gap_left <= nxt.gap;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result is checked against the oldest outstanding outcome.
	always @(posedge clk) begin : monitor
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result removed=%0d status=%0d occ=%0d",
						removed_value, status, occupancy);
			end else begin
				want = outcome_q.pop_front();
				n_checked++;
				if (removed_value !== want.removed || status !== want.st
						|| occupancy !== want.occ) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: result %0d expected removed=%0d status=%s occ=%0d,",
							" got removed=%0d status=%0d occ=%0d"},
							n_checked, want.removed, want.st.name(), want.occ,
							removed_value, status, occupancy);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned mode, len, made;
		bit quiet, narrow;
		logic cmd;
		logic [mps_pkg::FIELD_W-1:0] val;

		// Directed part: remove on empty, walking bits, duplicated maxima, insert on full.
		push_req(mps_pkg::CMD_REMOVE, 16'h1234, 0);
		push_req(mps_pkg::CMD_INSERT, 16'h0000, 0);
		push_req(mps_pkg::CMD_INSERT, 16'hFFFF, 1);
		push_req(mps_pkg::CMD_INSERT, 16'hFFFF, 0);
		for (int i = 0; i < 13; i++)
			push_req(mps_pkg::CMD_INSERT, mps_pkg::FIELD_W'(1) << i, i % 3);
		push_req(mps_pkg::CMD_INSERT, 16'h8000, 0);
		push_req(mps_pkg::CMD_REMOVE, 16'hFFFF, 0);
		push_req(mps_pkg::CMD_REMOVE, 16'h0000, 2);
		push_req(mps_pkg::CMD_REMOVE, 16'hAAAA, 0);
		push_drain();

		// Random part: runs that lean toward filling or draining, or mix inserts and removes evenly.
		made = 0;
		while (made < NUM_RANDOM) begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 48);
			quiet = ($urandom_range(0, 3) == 0);
			narrow = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: cmd = ($urandom_range(0, 99) < 85) ? mps_pkg::CMD_INSERT
						: mps_pkg::CMD_REMOVE;
					1: cmd = ($urandom_range(0, 99) < 85) ? mps_pkg::CMD_REMOVE
						: mps_pkg::CMD_INSERT;
					default: cmd = 1'($urandom_range(0, 1));
				endcase
				if (narrow)
					val = mps_pkg::FIELD_W'($urandom_range(0, 7));
				else if ($urandom_range(0, 7) == 0)
					val = 16'hFFFF - mps_pkg::FIELD_W'($urandom_range(0, 3));
				else
					val = mps_pkg::FIELD_W'($urandom());
				push_req(cmd, val, quiet ? 0 : $urandom_range(0, 7));
			end
			made += len;
			if (made >= NUM_RANDOM / 2 && made - len < NUM_RANDOM / 2)
				push_drain();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(request_q.size() == 0 && !start && outcome_q.size() == 0))
			@(posedge clk);
		repeat (5) @(posedge clk);
		$display("Checked %0d results: %0d inserts, %0d removes,", n_checked, n_insert, n_remove);
		$display("%0d inserts dropped on a full store, %0d removes on an empty store.",
			n_full, n_empty);
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("Mismatches: %0d", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
